@@ src/ile_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list engine package
// Command codes, field widths and the control bundle that the top level
// broadcasts to every element cell.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned COUNT_W = 9;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PUT       = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POP_FIRST = 4'd5;
    localparam logic [CMD_W-1:0] CMD_POP_AT    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_POP_LAST  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SET_SIZE  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_FIRST     = 4'd10;
    localparam logic [CMD_W-1:0] CMD_LAST      = 4'd11;

    // Per-cycle control shared by all cells. Each cell compares its own
    // index against the ranges below.
    typedef struct packed {
        logic              fill_en;   // fill_lo <= i < fill_hi loads fill_data
        logic [POS_W-1:0]  fill_lo;
        logic [POS_W-1:0]  fill_hi;
        logic [DATA_W-1:0] fill_data;
        logic              put_en;    // i == put_idx loads put_data
        logic [POS_W-1:0]  put_idx;
        logic [DATA_W-1:0] put_data;
        logic              shr_en;    // shr_lo < i <= shr_hi takes left neighbor
        logic [POS_W-1:0]  shr_lo;
        logic [POS_W-1:0]  shr_hi;
        logic              shl_en;    // shl_lo <= i < shl_hi takes right neighbor
        logic [POS_W-1:0]  shl_lo;
        logic [POS_W-1:0]  shl_hi;
        logic              rd_en;     // i == rd_idx drives its value out
        logic [POS_W-1:0]  rd_idx;
    } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/indexed_list_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result passes the first-stage registers, then the output register.
// Throughput: one request per cycle unless the output stalls; every command,
// insert and remove included, updates all cells in the cycle it is accepted.
// Reads are gathered by a two-stage registered OR tree.
// Reset clears the element count and the pipeline valid flags; element
// cells are not cleared and are only read below the element count.
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 32-bit values held in a row of cells, with append,
// prepend, insert, put, remove, pop, read and resize commands.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
    parameter int unsigned CAPACITY = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [ile_pkg::CMD_W-1:0]         command,
    input  logic [ile_pkg::POS_W-1:0]         position,
    input  logic signed [ile_pkg::DATA_W-1:0] value,
    input  logic signed [ile_pkg::DATA_W-1:0] fill_value,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic signed [ile_pkg::DATA_W-1:0] read_value,
    output logic [ile_pkg::COUNT_W-1:0]       count,
    output logic                              status
);
    import ile_pkg::*;

    localparam int unsigned CW     = $clog2(CAPACITY + 1);
    localparam int unsigned GROUP  = 16;
    localparam int unsigned NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    logic              cmd_accept;
    logic              advance;

    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              ok;
    cell_ctl_t         ctl;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] rd_vec    [NGROUP*GROUP];
    logic [DATA_W-1:0] grp_q     [NGROUP];

    logic              s1_valid_reg;
    logic [CW-1:0]     s1_cnt_reg;
    logic              s1_status_reg;

    logic              result_valid_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [COUNT_W-1:0] count_reg;
    logic              status_reg;
    logic [DATA_W-1:0] rd_sum;

    logic [POS_W-1:0]  n16;
    logic [POS_W-1:0]  n_m1;
    logic [POS_W-1:0]  cap16;
    logic [POS_W-1:0]  cnt16_next;

    // Handshake: the first stage empties whenever the output can take it.
    assign advance    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign cmd_ready  = !s1_valid_reg || advance;
    assign cmd_accept = cmd_valid && cmd_ready;

    assign n16   = POS_W'(cnt_reg);
    assign n_m1  = n16 - POS_W'(1);
    assign cap16 = POS_W'(CAPACITY);

    // Command decode into the broadcast cell control and the new count.
    always_comb
    begin
        ctl           = '0;
        ok            = 1'b1;
        cnt16_next    = n16;
        ctl.put_data  = value;
        ctl.fill_data = fill_value;
        ctl.put_idx   = position;
        ctl.fill_lo   = n16;
        ctl.fill_hi   = position;
        ctl.shr_lo    = position;
        ctl.shr_hi    = n16;
        ctl.shl_lo    = position;
        ctl.shl_hi    = n_m1;
        ctl.rd_idx    = position;
        unique case (command)
            CMD_APPEND:
            begin
                if (n16 == cap16)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    ctl.put_en  = 1'b1;
                    ctl.put_idx = n16;
                    cnt16_next  = n16 + POS_W'(1);
                end
            end
            CMD_PREPEND:
            begin
                if (n16 == cap16)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    ctl.put_en  = 1'b1;
                    ctl.put_idx = '0;
                    ctl.shr_en  = 1'b1;
                    ctl.shr_lo  = '0;
                    cnt16_next  = n16 + POS_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (position >= n16)
                begin
                    if (position >= cap16)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        ctl.fill_en   = 1'b1;
                        ctl.fill_data = '0;
                        ctl.put_en    = 1'b1;
                        cnt16_next    = position + POS_W'(1);
                    end
                end
                else if (n16 == cap16)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    ctl.shr_en = 1'b1;
                    ctl.put_en = 1'b1;
                    cnt16_next = n16 + POS_W'(1);
                end
            end
            CMD_PUT:
            begin
                if (position >= n16)
                begin
                    if (position >= cap16)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        ctl.fill_en = 1'b1;
                        ctl.put_en  = 1'b1;
                        cnt16_next  = position + POS_W'(1);
                    end
                end
                else
                begin
                    ctl.put_en = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (position < n16)
                begin
                    ctl.shl_en = 1'b1;
                    cnt16_next = n_m1;
                end
            end
            CMD_POP_FIRST:
            begin
                if (n16 != '0)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = '0;
                    ctl.shl_en = 1'b1;
                    ctl.shl_lo = '0;
                    cnt16_next = n_m1;
                end
            end
            CMD_POP_AT:
            begin
                if (position < n16)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.shl_en = 1'b1;
                    cnt16_next = n_m1;
                end
            end
            CMD_POP_LAST:
            begin
                if (n16 != '0)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_idx = n_m1;
                    cnt16_next = n_m1;
                end
            end
            CMD_READ:
            begin
                ctl.rd_en = (position < n16);
            end
            CMD_SET_SIZE:
            begin
                if (position > cap16)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    ctl.fill_en = 1'b1;
                    cnt16_next  = position;
                end
            end
            CMD_FIRST:
            begin
                ctl.rd_en  = (n16 != '0);
                ctl.rd_idx = '0;
            end
            CMD_LAST:
            begin
                ctl.rd_en  = (n16 != '0);
                ctl.rd_idx = n_m1;
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase

        // Nothing moves unless a request is taken this cycle.
        ctl.fill_en = ctl.fill_en && cmd_accept;
        ctl.put_en  = ctl.put_en  && cmd_accept;
        ctl.shr_en  = ctl.shr_en  && cmd_accept;
        ctl.shl_en  = ctl.shl_en  && cmd_accept;
        ctl.rd_en   = ctl.rd_en   && cmd_accept;
        cnt_next    = CW'(cnt16_next);
    end

    // Row of element cells, each wired to its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        ile_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (rd_vec[i])
        );
    end

    // Pad the read vector up to a whole number of groups.
    for (genvar i = CAPACITY; i < NGROUP * GROUP; i++)
    begin : g_pad
        assign rd_vec[i] = '0;
    end

    // First read stage: OR each group of cell outputs into a register.
    for (genvar g = 0; g < NGROUP; g++)
    begin : g_grp
        logic [DATA_W-1:0] or_val;
        logic [DATA_W-1:0] grp_reg;

        always_comb
        begin
            or_val = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                or_val = or_val | rd_vec[g*GROUP + j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd_accept)
            begin
                grp_reg <= or_val;
            end
        end

        assign grp_q[g] = grp_reg;
    end

    // Second read stage: OR of all group registers.
    always_comb
    begin
        rd_sum = '0;
        for (int g = 0; g < NGROUP; g++)
        begin
            rd_sum = rd_sum | grp_q[g];
        end
    end

    // Element count and first-stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                cnt_reg      <= ok ? cnt_next : cnt_reg;
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // First-stage payload.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_cnt_reg    <= ok ? cnt_next : cnt_reg;
            s1_status_reg <= !ok;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_value_reg <= rd_sum;
            count_reg      <= COUNT_W'(s1_cnt_reg);
            status_reg     <= s1_status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign read_value   = read_value_reg;
    assign count        = count_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

@@ src/ile_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed list engine element cell
// Holds one list element and loads it from the request, from a fill value
// or from a neighbor cell, as the broadcast control selects.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                      clk,
    input  ile_pkg::cell_ctl_t        ctl,
    input  logic [ile_pkg::DATA_W-1:0] left_data,
    input  logic [ile_pkg::DATA_W-1:0] right_data,
    output logic [ile_pkg::DATA_W-1:0] data,
    output logic [ile_pkg::DATA_W-1:0] rd_data
);
    import ile_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Select the next element value; a direct write wins over a shift.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.put_en && (IDX == ctl.put_idx))
        begin
            data_next = ctl.put_data;
        end
        else if (ctl.shr_en && (IDX > ctl.shr_lo) && (IDX <= ctl.shr_hi))
        begin
            data_next = left_data;
        end
        else if (ctl.shl_en && (IDX >= ctl.shl_lo) && (IDX < ctl.shl_hi))
        begin
            data_next = right_data;
        end
        else if (ctl.fill_en && (IDX >= ctl.fill_lo) && (IDX < ctl.fill_hi))
        begin
            data_next = ctl.fill_data;
        end
    end

    // Element storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // The addressed cell drives its current value, all others drive zero.
    assign rd_data = (ctl.rd_en && (IDX == ctl.rd_idx)) ? data_reg : '0;
    assign data    = data_reg;

endmodule
`default_nettype wire

@@ tb/tb_indexed_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives list commands through the request channel with bursty timing and
// checks each response against a behavioral copy of the list kept in the
// testbench. Directed requests cover empty-list reads, growth with gap fill,
// capacity refusal, out-of-range accesses and spare command codes. These are
// followed by a long random run with receiver backpressure.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine_unit;

    import ile_pkg::*;

    localparam int unsigned LIST_CAP    = 256;
    localparam int unsigned RANDOM_REQS = 1200;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_AFTER  = 400;
    localparam int unsigned HOLD_CYCLES = 120;

    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] fill;
    } list_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
        logic                     status;
    } list_rsp_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_ready;
    logic [CMD_W-1:0]         command = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic signed [DATA_W-1:0] fill_value = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
    logic                     status;

    indexed_list_engine_unit #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .position    (position),
        .value       (value),
        .fill_value  (fill_value),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .read_value  (read_value),
        .count       (count),
        .status      (status)
    );

    // Clock.
    always #6 clk = ~clk;

    list_req_t   req_backlog[$];
    list_rsp_t   rsp_expected[$];
    int unsigned fail_count = 0;
    int unsigned accepted_reqs = 0;
    int unsigned cycle_count = 0;
    logic        req_taken = 1'b0;
    logic        long_hold = 1'b0;

    // Shadow copy of the list.
    logic signed [DATA_W-1:0] shadow_elems [0:LIST_CAP-1];
    int unsigned              shadow_count = 0;

    // Value at an index, or zero when the index is past the end.
    function automatic logic signed [DATA_W-1:0] peek_slot(int unsigned idx);
        if (idx < shadow_count)
            return shadow_elems[idx];
        return '0;
    endfunction

    // Grow to a new size with a fill value, or shrink to it.
    function automatic void size_to(int unsigned new_size, logic signed [DATA_W-1:0] fill);
        for (int unsigned k = shadow_count; k < new_size; k++)
            shadow_elems[k] = fill;
        shadow_count = new_size;
    endfunction

    // Close the gap left by removing one element.
    function automatic void drop_slot(int unsigned idx);
        if (idx >= shadow_count)
            return;
        for (int unsigned k = idx + 1; k < shadow_count; k++)
            shadow_elems[k - 1] = shadow_elems[k];
        shadow_count--;
    endfunction

    // Open a slot and store a value there; zero fill when past the end.
    function automatic logic open_slot(int unsigned idx, logic signed [DATA_W-1:0] val);
        if (idx >= shadow_count) begin
            if (idx + 1 > LIST_CAP)
                return 1'b0;
            size_to(idx + 1, '0);
            shadow_elems[idx] = val;
            return 1'b1;
        end
        if (shadow_count + 1 > LIST_CAP)
            return 1'b0;
        for (int unsigned k = shadow_count; k > idx; k--)
            shadow_elems[k] = shadow_elems[k - 1];
        shadow_elems[idx] = val;
        shadow_count++;
        return 1'b1;
    endfunction

    // Apply one command to the shadow list and return its response.
    function automatic list_rsp_t predict_list_response(list_req_t r);
        list_rsp_t                rsp;
        logic signed [DATA_W-1:0] rd;
        logic                     ok;
        int unsigned              idx;
        rd = '0;
        ok = 1'b1;
        idx = r.pos;
        case (r.cmd)
            CMD_APPEND:  ok = open_slot(shadow_count, r.val);
            CMD_PREPEND: ok = open_slot(0, r.val);
            CMD_INSERT:  ok = open_slot(idx, r.val);
            CMD_PUT:
            begin
                if (idx >= shadow_count && idx + 1 > LIST_CAP) begin
                    ok = 1'b0;
                end
                else begin
                    if (idx >= shadow_count)
                        size_to(idx + 1, r.fill);
                    shadow_elems[idx] = r.val;
                end
            end
            CMD_REMOVE: drop_slot(idx);
            CMD_POP_FIRST:
            begin
                rd = peek_slot(0);
                drop_slot(0);
            end
            CMD_POP_AT:
            begin
                rd = peek_slot(idx);
                drop_slot(idx);
            end
            CMD_POP_LAST:
            begin
                if (shadow_count > 0) begin
                    rd = peek_slot(shadow_count - 1);
                    drop_slot(shadow_count - 1);
                end
            end
            CMD_READ: rd = peek_slot(idx);
            CMD_SET_SIZE:
            begin
                if (idx > LIST_CAP)
                    ok = 1'b0;
                else
                    size_to(idx, r.fill);
            end
            CMD_FIRST: rd = peek_slot(0);
            CMD_LAST:
            begin
                if (shadow_count > 0)
                    rd = peek_slot(shadow_count - 1);
            end
            default: ;
        endcase
        rsp.read_value = ok ? rd : '0;
        rsp.count = COUNT_W'(shadow_count);
        rsp.status = ~ok;
        return rsp;
    endfunction

    task automatic add_req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] val, logic [DATA_W-1:0] fill);
        list_req_t r;
        r.cmd = cmd;
        r.pos = pos;
        r.val = val;
        r.fill = fill;
        req_backlog.push_back(r);
    endtask

    // Random request: mostly positions near the head of the list, some up to
    // just past the capacity and a few anywhere in the 16-bit range.
    function automatic list_req_t random_request();
        list_req_t   r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)      r.cmd = CMD_APPEND;
        else if (roll < 20) r.cmd = CMD_PREPEND;
        else if (roll < 30) r.cmd = CMD_INSERT;
        else if (roll < 40) r.cmd = CMD_PUT;
        else if (roll < 48) r.cmd = CMD_REMOVE;
        else if (roll < 54) r.cmd = CMD_POP_FIRST;
        else if (roll < 62) r.cmd = CMD_POP_AT;
        else if (roll < 68) r.cmd = CMD_POP_LAST;
        else if (roll < 82) r.cmd = CMD_READ;
        else if (roll < 89) r.cmd = CMD_SET_SIZE;
        else if (roll < 93) r.cmd = CMD_FIRST;
        else if (roll < 97) r.cmd = CMD_LAST;
        else                r.cmd = CMD_SPARE_LO + CMD_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 55)      r.pos = POS_W'($urandom_range(0, 24));
        else if (roll < 88) r.pos = POS_W'($urandom_range(0, LIST_CAP + 14));
        else                r.pos = POS_W'($urandom);
        if (r.cmd == CMD_SET_SIZE && $urandom_range(0, 2) == 0)
            r.pos = POS_W'($urandom_range(LIST_CAP - 1, LIST_CAP + 1));
        case ($urandom_range(0, 9))
            0:       r.val = 32'sh7fffffff;
            1:       r.val = 32'sh80000000;
            default: r.val = $urandom;
        endcase
        r.fill = $urandom;
        return r;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge clk) begin : drive_requests
        list_req_t nxt;
        if (rst_n) begin
            if (cmd_valid && !req_taken) begin
                // Hold the current request until it is taken.
            end
            else if (gap_left > 0 && !long_hold) begin
                cmd_valid <= 1'b0;
                gap_left--;
            end
            else if (req_backlog.size() > 0) begin
                nxt = req_backlog.pop_front();
                command <= nxt.cmd;
                position <= nxt.pos;
                value <= nxt.val;
                fill_value <= nxt.fill;
                cmd_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else begin
                    burst_left--;
                end
            end
            else begin
                cmd_valid <= 1'b0;
            end
        end
    end

    // Response receiver: segments of free flow, random and heavy stalls,
    // plus one long hold-off so the block fills and stalls its input.
    int unsigned seg_left = 0;
    int unsigned seg_mode = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                long_hold <= 1'b1;
                result_ready <= 1'b0;
            end
            else begin
                long_hold <= 1'b0;
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (seg_mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= $urandom_range(0, 1);
                    default: result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: check responses in order, then predict for new requests.
    always @(posedge clk) begin : watch_channels
        list_rsp_t want;
        list_req_t got_req;
        if (rst_n) begin
            req_taken <= cmd_valid && cmd_ready;
            if (result_valid && result_ready) begin
                if (rsp_expected.size() == 0) begin
                    fail_count++;
                    $display("%0t: response with no request pending: read_value %0d count %0d",
                             $time, read_value, count);
                end
                else begin
                    want = rsp_expected.pop_front();
                    if (read_value !== want.read_value) begin
                        fail_count++;
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, read_value);
                    end
                    if (count !== want.count) begin
                        fail_count++;
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, count);
                    end
                    if (status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                end
            end
            if (cmd_valid && cmd_ready) begin
                got_req.cmd = command;
                got_req.pos = position;
                got_req.val = value;
                got_req.fill = fill_value;
                rsp_expected.push_back(predict_list_response(got_req));
                accepted_reqs <= accepted_reqs + 1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_indexed_list_engine_unit failed");
            $finish;
        end
    end

    initial begin
        // Reads and pops on the empty list.
        add_req(CMD_FIRST, 16'd0, 32'h0, 32'h0);
        add_req(CMD_LAST, 16'd0, 32'h0, 32'h0);
        add_req(CMD_POP_FIRST, 16'd0, 32'h0, 32'h0);
        add_req(CMD_POP_LAST, 16'd0, 32'h0, 32'h0);
        // Building up, including insert and put past the end.
        add_req(CMD_APPEND, 16'd0, 32'h7fffffff, 32'h0);
        add_req(CMD_PREPEND, 16'd0, 32'h80000000, 32'hffffffff);
        add_req(CMD_INSERT, 16'd1, 32'hffffffff, 32'h0);
        add_req(CMD_INSERT, 16'd6, 32'h12345678, 32'hffffffff);
        add_req(CMD_PUT, 16'd2, 32'h55555555, 32'h0);
        add_req(CMD_PUT, 16'd10, 32'haaaaaaaa, 32'hffffffff);
        add_req(CMD_READ, 16'd8, 32'h0, 32'h0);
        add_req(CMD_READ, 16'hffff, 32'hffffffff, 32'hffffffff);
        // Removal, in and out of range.
        add_req(CMD_REMOVE, 16'd0, 32'h0, 32'h0);
        add_req(CMD_REMOVE, 16'd40000, 32'h0, 32'h0);
        add_req(CMD_POP_AT, 16'd2, 32'h0, 32'h0);
        add_req(CMD_POP_AT, 16'd300, 32'h0, 32'h0);
        add_req(CMD_POP_FIRST, 16'd0, 32'h0, 32'h0);
        add_req(CMD_POP_LAST, 16'd0, 32'h0, 32'h0);
        // Fill to capacity, then every kind of refused growth.
        add_req(CMD_SET_SIZE, 16'(LIST_CAP), 32'h0, 32'h0f0f0f0f);
        add_req(CMD_APPEND, 16'd0, 32'h1, 32'h0);
        add_req(CMD_PREPEND, 16'd0, 32'h2, 32'h0);
        add_req(CMD_INSERT, 16'd10, 32'h3, 32'h0);
        add_req(CMD_PUT, 16'(LIST_CAP), 32'h4, 32'h0);
        add_req(CMD_PUT, 16'(LIST_CAP - 1), 32'h5, 32'h0);
        add_req(CMD_LAST, 16'd0, 32'h0, 32'h0);
        add_req(CMD_SET_SIZE, 16'(LIST_CAP + 1), 32'h0, 32'h0);
        add_req(CMD_SET_SIZE, 16'd0, 32'h0, 32'h0);
        add_req(CMD_SPARE_LO, 16'hffff, 32'hffffffff, 32'hffffffff);
        add_req(CMD_SPARE_HI, 16'd0, 32'h0, 32'h0);
        for (int unsigned n = 0; n < RANDOM_REQS; n++)
            req_backlog.push_back(random_request());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || cmd_valid || rsp_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && rsp_expected.size() == 0) begin
            $display("tb_indexed_list_engine_unit passed");
        end
        else begin
            $display("tb_indexed_list_engine_unit failed");
        end
        $finish;
    end

endmodule
